// ----- hw/rtl/piu_pkg.sv -----
// Shared types and constants for the packed index palette unpacker.
`default_nettype none

package piu_pkg;

   // Field widths fixed by the interface
   localparam int IDX_W       = 8;
   localparam int COLOR_W     = 32;
   localparam int DEPTH_W     = 2;
   localparam int ROW_WIDTH_W = 13;
   localparam int PIX_POS_W   = 3;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   // Defaults for the top-level parameters
   localparam int MAX_ROW_WIDTH_DEF   = 4096;
   localparam int PALETTE_ENTRIES_DEF = 256;

   // Register reset values
   localparam logic [DEPTH_W-1:0]     PIXEL_DEPTH_RESET = 2'd3;
   localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET   = 13'd640;
   localparam logic                   BYPASS_RESET      = 1'b0;

   // Transaction operation codes
   localparam logic OP_PIXEL     = 1'b0;
   localparam logic OP_PAL_WRITE = 1'b1;

   typedef enum logic [1:0] {
      REG_PIXEL_DEPTH    = 2'd0,
      REG_ROW_WIDTH      = 2'd1,
      REG_PALETTE_BYPASS = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [DEPTH_W-1:0]     pixel_depth;
      logic [ROW_WIDTH_W-1:0] row_width;
      logic                   palette_bypass;
   } cfg_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic             in_range;
      logic             row_end;
      logic             last;
   } pixel_type;

endpackage

`default_nettype wire

// ----- hw/rtl/piu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module piu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/piu_csr.sv -----
// APB-style configuration registers of the palette unpacker.
`default_nettype none

module piu_csr
   import piu_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready,
   output      cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;
   logic [1:0] reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_PIXEL_DEPTH:    cfg_in.pixel_depth    = csr_pwdata[DEPTH_W-1:0];
            REG_ROW_WIDTH:      cfg_in.row_width      = csr_pwdata[ROW_WIDTH_W-1:0];
            REG_PALETTE_BYPASS: cfg_in.palette_bypass = csr_pwdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_PIXEL_DEPTH:    csr_prdata = CSR_DATA_W'(cfg_ff.pixel_depth);
         REG_ROW_WIDTH:      csr_prdata = CSR_DATA_W'(cfg_ff.row_width);
         REG_PALETTE_BYPASS: csr_prdata = CSR_DATA_W'(cfg_ff.palette_bypass);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_depth    <= PIXEL_DEPTH_RESET;
         cfg_ff.row_width      <= ROW_WIDTH_RESET;
         cfg_ff.palette_bypass <= BYPASS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/piu_unpack.sv -----
// Input register, pixel slicer and column counter of the palette unpacker.
`default_nettype none

module piu_unpack
   import piu_pkg::*;
#(
   parameter int MAX_ROW_WIDTH   = MAX_ROW_WIDTH_DEF,
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire logic                               req_op,
   input  wire logic [IDX_W-1:0]                   req_src_byte,
   input  wire logic [IDX_W-1:0]                   req_pal_index,
   input  wire logic [COLOR_W-1:0]                 req_pal_color,
   input  wire cfg_type                            cfg,
   input  wire logic                               out_ready,
   output      logic                               emit,
   output      pixel_type                          pix,
   output      logic                               ram_we,
   output      logic [$clog2(PALETTE_ENTRIES)-1:0] ram_waddr,
   output      logic [COLOR_W-1:0]                 ram_wdata,
   output      logic [$clog2(PALETTE_ENTRIES)-1:0] ram_raddr
);

   localparam int CNT_W = $clog2(MAX_ROW_WIDTH);
   localparam int CMP_W = ((CNT_W > ROW_WIDTH_W) ? CNT_W : ROW_WIDTH_W) + 1;
   localparam int AW    = $clog2(PALETTE_ENTRIES);

   logic                 a_valid_ff, a_valid_in;
   logic                 a_op_ff;
   logic [IDX_W-1:0]     a_byte_ff;
   logic [IDX_W-1:0]     a_pal_index_ff;
   logic [COLOR_W-1:0]   a_pal_color_ff;
   logic [PIX_POS_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   logic                 a_load, a_done, is_write;
   logic [3:0]           bits, pos_next, shift;
   logic [IDX_W-1:0]     mask, idx;
   logic                 byte_last, row_end;
   logic [CMP_W-1:0]     eff_width, rw_ext;

   assign is_write = a_valid_ff && (a_op_ff == OP_PAL_WRITE);

   // Pixel position within the byte, leftmost pixel in the top bits
   assign bits      = 4'd1 << cfg.pixel_depth;
   assign pos_next  = {1'b0, pos_ff} + 4'd1;
   assign shift     = 4'd8 - (pos_next << cfg.pixel_depth);
   assign mask      = IDX_W'((9'd1 << bits) - 9'd1);
   assign idx       = (a_byte_ff >> shift) & mask;
   assign byte_last = (pos_ff == PIX_POS_W'((4'd8 >> cfg.pixel_depth) - 4'd1));

   // Row width clamped to the range one through MAX_ROW_WIDTH
   assign rw_ext = CMP_W'(cfg.row_width);
   always_comb begin
      if (rw_ext == '0) begin
         eff_width = CMP_W'(1);
      end else if (rw_ext > CMP_W'(MAX_ROW_WIDTH)) begin
         eff_width = CMP_W'(MAX_ROW_WIDTH);
      end else begin
         eff_width = rw_ext;
      end
   end

   assign row_end = (CMP_W'(count_ff) + CMP_W'(1)) >= eff_width;

   assign emit      = a_valid_ff && (a_op_ff == OP_PIXEL) && out_ready;
   assign a_done    = is_write || (emit && (row_end || byte_last));
   assign req_stall = a_valid_ff && !a_done;
   assign a_load    = req_valid && !req_stall;

   assign pix.idx      = idx;
   assign pix.in_range = ({1'b0, idx} < (IDX_W + 1)'(PALETTE_ENTRIES));
   assign pix.row_end  = row_end;
   assign pix.last     = row_end || byte_last;

   assign ram_we    = is_write &&
                      ({1'b0, a_pal_index_ff} < (IDX_W + 1)'(PALETTE_ENTRIES));
   assign ram_waddr = a_pal_index_ff[AW-1:0];
   assign ram_wdata = a_pal_color_ff;
   assign ram_raddr = idx[AW-1:0];

   always_comb begin
      a_valid_in = a_valid_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      if (a_done) begin
         a_valid_in = 1'b0;
      end
      if (emit) begin
         pos_in   = pos_ff + PIX_POS_W'(1);
         count_in = row_end ? '0 : CNT_W'(CMP_W'(count_ff) + CMP_W'(1));
      end
      if (a_load) begin
         a_valid_in = 1'b1;
         pos_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         pos_ff     <= '0;
         count_ff   <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         pos_ff     <= pos_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_op_ff        <= req_op;
         a_byte_ff      <= req_src_byte;
         a_pal_index_ff <= req_pal_index;
         a_pal_color_ff <= req_pal_color;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/packed_index_palette_unpacker.sv -----
// Top level of the packed index palette unpacker: input stage, palette RAM and result stage.
`default_nettype none

// Each request transaction either writes one palette entry or carries one framebuffer
// byte holding 1, 2, 4 or 8 bits per pixel, leftmost pixel in the most significant bits.
// A palette write gives no result. A framebuffer byte gives one result transaction per
// pixel, one per cycle while the result side is not stalled; when the row ends inside
// the byte, the remaining pixels of that byte are dropped and give no result.
// The input register hands out one pixel per cycle to the palette RAM read port, but
// only while the result side is not stalled. A new request is taken in the same cycle
// as the previous one issues its final pixel. The palette read is registered, so a
// pixel appears at the result port in the cycle after it leaves the input register;
// the result register holds it, and the RAM read data is frozen, for as long as the
// result side stalls. The column counter follows the configured
// row width (zero acts as one, widths above MAX_ROW_WIDTH are clamped) and marks the
// last visible pixel of a row with row_end; last marks the final result of each byte.
// Palette entries must be written before they are looked up; entries at or beyond
// PALETTE_ENTRIES are never stored and look up as zero. In bypass mode the result is
// the zero-extended index. Configuration should only be written while the block is idle.

module packed_index_palette_unpacker
   import piu_pkg::*;
#(
   parameter int MAX_ROW_WIDTH   = MAX_ROW_WIDTH_DEF,
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic                  req_op,
   input  wire logic [IDX_W-1:0]      req_src_byte,
   input  wire logic [IDX_W-1:0]      req_pal_index,
   input  wire logic [COLOR_W-1:0]    req_pal_color,
   // Result channel
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic [COLOR_W-1:0]    rsp_pixel_value,
   output      logic                  rsp_row_end,
   output      logic                  rsp_last,
   // Configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   localparam int AW = $clog2(PALETTE_ENTRIES);

   cfg_type          cfg;
   pixel_type        pix;
   pixel_type        b_pix_ff;
   logic             b_valid_ff, b_valid_in;
   logic             b_load, emit;
   logic             ram_we;
   logic [AW-1:0]    ram_waddr, ram_raddr;
   logic [COLOR_W-1:0] ram_wdata, ram_rdata;

   piu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The result register may take a new pixel when it is empty or being taken.
   assign b_load = !b_valid_ff || !rsp_stall;

   piu_unpack #(
      .MAX_ROW_WIDTH   (MAX_ROW_WIDTH),
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_unpack (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_src_byte  (req_src_byte),
      .req_pal_index (req_pal_index),
      .req_pal_color (req_pal_color),
      .cfg           (cfg),
      .out_ready     (b_load),
      .emit          (emit),
      .pix           (pix),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_raddr     (ram_raddr)
   );

   // The palette is read only when a pixel enters the result register, so the read
   // data stays put while that pixel waits on a stalled result channel.
   piu_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (emit),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      b_valid_in = b_valid_ff;
      if (b_load) begin
         b_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_load && emit) begin
         b_pix_ff <= pix;
      end
   end

   // Bypass gives the raw index; an index beyond the palette looks up as zero.
   always_comb begin
      if (cfg.palette_bypass) begin
         rsp_pixel_value = COLOR_W'(b_pix_ff.idx);
      end else if (b_pix_ff.in_range) begin
         rsp_pixel_value = ram_rdata;
      end else begin
         rsp_pixel_value = '0;
      end
   end

   assign rsp_valid   = b_valid_ff;
   assign rsp_row_end = b_pix_ff.row_end;
   assign rsp_last    = b_pix_ff.last;

   // A row that ends inside a byte must also close that byte.
   a_row_end_closes_byte: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_row_end || rsp_last)
   ) else $error("row_end given without last");

   // A palette write and a palette lookup never come from the same request.
   a_no_write_with_read: assert property (
      @(posedge clock) disable iff (reset)
      !(ram_we && emit)
   ) else $error("palette written and read in the same cycle");

   // The read data of a waiting result must not be overwritten.
   a_read_held_on_stall: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !emit
   ) else $error("palette read issued while the result is stalled");

endmodule

`default_nettype wire

// ----- tb/packed_index_palette_unpacker_tb.sv -----
// Self-checking testbench for the packed index palette unpacker.
`default_nettype none

module packed_index_palette_unpacker_tb
   import piu_pkg::*;
();

   // Run control. The block holds at most one transaction in its input register and one
   // pixel in its result register, so a short drain covers anything still in flight after
   // the last expected result.
   localparam int DRAIN_CYCLES     = 16;
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int NUM_REGS         = 3;
   localparam int UNUSED_REG_INDEX = 3;
   localparam int RANDOM_PHASES    = 10;
   localparam int PHASE_ITEMS      = 50;
   localparam int MAX_WAIT         = 13;

   typedef struct packed {
      logic [COLOR_W-1:0] pixel_value;
      logic               row_end;
      logic               last;
   } pixel_result_type;

   // The scoreboard carries its own copy of the palette, the column counter and the
   // registers. Every accepted pixel request is unpacked here into the pixels it should
   // produce, and each result transaction is compared with the oldest of them.
   class pixel_scoreboard;
      logic [COLOR_W-1:0] color_table [PALETTE_ENTRIES_DEF];
      int unsigned        column_count;
      cfg_type            cfg;
      pixel_result_type   expected_pixels [$];
      int unsigned        errors;

      function new();
         column_count       = 0;
         cfg.pixel_depth    = PIXEL_DEPTH_RESET;
         cfg.row_width      = ROW_WIDTH_RESET;
         cfg.palette_bypass = BYPASS_RESET;
         errors             = 0;
      endfunction

      function void write_register(int unsigned index, logic [CSR_DATA_W-1:0] data);
         case (index)
            REG_PIXEL_DEPTH:    cfg.pixel_depth    = data[DEPTH_W-1:0];
            REG_ROW_WIDTH:      cfg.row_width      = data[ROW_WIDTH_W-1:0];
            REG_PALETTE_BYPASS: cfg.palette_bypass = data[0];
            default: ;
         endcase
      endfunction

      function void check_register(int unsigned index, logic [CSR_DATA_W-1:0] rdata);
         logic [CSR_DATA_W-1:0] want;
         case (index)
            REG_PIXEL_DEPTH:    want = CSR_DATA_W'(cfg.pixel_depth);
            REG_ROW_WIDTH:      want = CSR_DATA_W'(cfg.row_width);
            default:            want = CSR_DATA_W'(cfg.palette_bypass);
         endcase
         if (rdata !== want) begin
            $display("%0t: register %0d read expected %h actual %h", $time, index, want, rdata);
            errors++;
         end
      endfunction

      function void note_request(logic op, logic [IDX_W-1:0] src_byte,
                                 logic [IDX_W-1:0] pal_index, logic [COLOR_W-1:0] pal_color);
         int unsigned      bits;
         int unsigned      pixel_count;
         int unsigned      width;
         logic [IDX_W-1:0] idx;
         pixel_result_type pixel;
         bit               row_done;
         if (op == OP_PAL_WRITE) begin
            color_table[pal_index] = pal_color;
            return;
         end
         bits        = 1 << cfg.pixel_depth;
         pixel_count = 8 / bits;
         width       = cfg.row_width;
         if (width < 1)
            width = 1;
         if (width > MAX_ROW_WIDTH_DEF)
            width = MAX_ROW_WIDTH_DEF;
         row_done = 1'b0;
         for (int i = 0; i < pixel_count && !row_done; i++) begin
            idx = IDX_W'((src_byte >> (8 - bits * (i + 1))) & ((1 << bits) - 1));
            pixel.pixel_value = cfg.palette_bypass ? COLOR_W'(idx) : color_table[idx];
            pixel.row_end     = (column_count + 1 >= width);
            pixel.last        = pixel.row_end || (i == pixel_count - 1);
            expected_pixels.push_back(pixel);
            if (pixel.row_end) begin
               column_count = 0;
               row_done     = 1'b1;
            end else begin
               column_count++;
            end
         end
      endfunction

      function void check_result(logic [COLOR_W-1:0] pixel_value, logic row_end, logic last);
         pixel_result_type want;
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected result, actual pixel_value %h row_end %b last %b",
                     $time, pixel_value, row_end, last);
            errors++;
            return;
         end
         want = expected_pixels.pop_front();
         if (pixel_value !== want.pixel_value) begin
            $display("%0t: pixel_value expected %h actual %h",
                     $time, want.pixel_value, pixel_value);
            errors++;
         end
         if (row_end !== want.row_end) begin
            $display("%0t: row_end expected %b actual %b", $time, want.row_end, row_end);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, last);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return expected_pixels.size();
      endfunction
   endclass

   // Every input of the block starts at a known value.
   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_stall;
   logic                  req_op        = OP_PIXEL;
   logic [IDX_W-1:0]      req_src_byte  = '0;
   logic [IDX_W-1:0]      req_pal_index = '0;
   logic [COLOR_W-1:0]    req_pal_color = '0;
   logic                  rsp_valid;
   logic                  rsp_stall     = 1'b0;
   logic [COLOR_W-1:0]    rsp_pixel_value;
   logic                  rsp_row_end;
   logic                  rsp_last;
   logic                  csr_psel      = 1'b0;
   logic                  csr_penable   = 1'b0;
   logic                  csr_pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr     = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata    = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   pixel_scoreboard sb = new();

   // Palette entries that have been written so far. Lookups are only ever made of these,
   // since an entry that was never written has no defined colour.
   bit          palette_loaded [PALETTE_ENTRIES_DEF];
   int unsigned req_calm;
   int unsigned rsp_calm;
   int unsigned idle_cycles;

   packed_index_palette_unpacker i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_src_byte    (req_src_byte),
      .req_pal_index   (req_pal_index),
      .req_pal_color   (req_pal_color),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_row_end     (rsp_row_end),
      .rsp_last        (rsp_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Number of cycles a side holds off before its next transaction. Now and then a side
   // enters a calm stretch in which it never holds off, so that back-to-back traffic is
   // exercised as well as gaps of every length.
   function automatic int unsigned draw_wait(inout int unsigned calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm_left = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // Offers one request transaction, starting at a falling edge, and returns at the
   // falling edge after it has been accepted. Valid is left high, so the next call
   // either keeps it high or lowers it, but never both within one time step.
   task automatic send_request(logic op, logic [IDX_W-1:0] src_byte,
                               logic [IDX_W-1:0] pal_index, logic [COLOR_W-1:0] pal_color);
      int unsigned gap;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_src_byte  <= src_byte;
      req_pal_index <= pal_index;
      req_pal_color <= pal_color;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(op, src_byte, pal_index, pal_color);
      if (op == OP_PAL_WRITE)
         palette_loaded[pal_index] = 1'b1;
      @(negedge clock);
   endtask

   // One APB transfer: a setup cycle, then an access cycle that completes at the rising
   // edge where pready is high. Read data is taken at that same edge.
   task automatic csr_transfer(bit is_write, int unsigned index,
                               logic [CSR_DATA_W-1:0] wdata,
                               output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= CSR_ADDR_W'(index * 4);
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Registers are only touched while the block is idle: every expected pixel must have
   // come out, and a further drain lets a trailing palette write settle. Each register is
   // written and read back, and the unused address gets a junk write that the block has
   // to ignore. The column counter is deliberately left alone, so a narrower row width
   // can take effect in the middle of a row.
   task automatic configure(logic [CSR_DATA_W-1:0] depth_word,
                            logic [CSR_DATA_W-1:0] width_word,
                            logic [CSR_DATA_W-1:0] bypass_word);
      logic [CSR_DATA_W-1:0] words [NUM_REGS];
      logic [CSR_DATA_W-1:0] rdata;
      logic [CSR_DATA_W-1:0] junk;
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      words[REG_PIXEL_DEPTH]    = depth_word;
      words[REG_ROW_WIDTH]      = width_word;
      words[REG_PALETTE_BYPASS] = bypass_word;
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_transfer(1'b1, i, words[i], rdata);
         sb.write_register(i, words[i]);
         csr_transfer(1'b0, i, '0, rdata);
         sb.check_register(i, rdata);
      end
      junk = $urandom;
      csr_transfer(1'b1, UNUSED_REG_INDEX, junk, rdata);
      sb.write_register(UNUSED_REG_INDEX, junk);
   endtask

   // Result side: before each result transaction it may hold stall high for a drawn
   // number of cycles, then takes the result at the first rising edge with valid high.
   initial begin
      int unsigned wait_cycles;
      while (reset) @(negedge clock);
      forever begin
         wait_cycles = draw_wait(rsp_calm);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         sb.check_result(rsp_pixel_value, rsp_row_end, rsp_last);
         @(negedge clock);
      end
   end

   // The watchdog ends a run in which neither channel moves a transaction for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("packed_index_palette_unpacker: mismatch");
            $finish;
         end
      end
   end

   initial begin
      logic [IDX_W-1:0]      seed_entries [6];
      logic [IDX_W-1:0]      edge_bytes [5];
      logic [CSR_DATA_W-1:0] depth_word;
      logic [CSR_DATA_W-1:0] width_word;
      logic [CSR_DATA_W-1:0] bypass_word;
      logic [IDX_W-1:0]      pixel_byte;
      int unsigned           bits;
      int unsigned           cand;
      int unsigned           tries;
      seed_entries = '{8'h02, 8'h03, 8'h0f, 8'h80, 8'h7f, 8'hff};
      edge_bytes   = '{8'h00, 8'hff, 8'h0f, 8'h80, 8'h7f};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, first under the reset configuration: 8 bits per pixel, rows of
      // 640 pixels, palette lookup. Entry 0 gets all ones and entry 1 all zeros, and the
      // low entries are loaded so that every depth has colours to look up.
      send_request(OP_PAL_WRITE, IDX_W'($urandom), 8'h00, 32'hffff_ffff);
      send_request(OP_PAL_WRITE, IDX_W'($urandom), 8'h01, 32'h0000_0000);
      foreach (seed_entries[i])
         send_request(OP_PAL_WRITE, IDX_W'($urandom), seed_entries[i], $urandom);
      foreach (edge_bytes[i])
         send_request(OP_PIXEL, edge_bytes[i], IDX_W'($urandom), $urandom);

      // One bit per pixel with a row width of zero, which must behave as a width of one:
      // every byte ends its row on the first pixel and drops the other seven.
      configure(0, 0, 0);
      send_request(OP_PIXEL, 8'ha5, IDX_W'($urandom), $urandom);
      send_request(OP_PIXEL, 8'h5a, IDX_W'($urandom), $urandom);

      // Two bits per pixel in bypass mode. Junk above the register widths must be masked
      // off, and the all-ones width then clamps to the maximum row width.
      configure(32'hffff_fffd, 32'hffff_ffff, 32'hffff_ffff);
      send_request(OP_PIXEL, 8'he4, IDX_W'($urandom), $urandom);
      send_request(OP_PIXEL, 8'h1b, IDX_W'($urandom), $urandom);

      // Four bits per pixel with three-pixel rows, so the first and third bytes each end their
      // row on their first pixel and their second pixel is dropped.
      configure(2, 3, 0);
      send_request(OP_PIXEL, 8'hf0, IDX_W'($urandom), $urandom);
      send_request(OP_PIXEL, 8'h0f, IDX_W'($urandom), $urandom);
      send_request(OP_PIXEL, 8'h3f, IDX_W'($urandom), $urandom);

      // Lowering the width in the middle of a row: after eight pixels of a twenty-pixel
      // row the width drops to five, so the very next pixel has to end the row.
      configure(0, 20, 0);
      send_request(OP_PIXEL, 8'hff, IDX_W'($urandom), $urandom);
      configure(0, 5, 0);
      send_request(OP_PIXEL, 8'h00, IDX_W'($urandom), $urandom);

      // Random part. The first two phases pin the extremes of depth and row width; the
      // rest mostly use short rows, so that row ends fall at every position in a byte,
      // with the occasional zero, maximum, over-range or mid-sized width.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         depth_word  = $urandom_range(0, 3);
         bypass_word = $urandom_range(0, 1);
         case ($urandom_range(0, 9))
            6:       width_word = 0;
            7:       width_word = MAX_ROW_WIDTH_DEF;
            8:       width_word = $urandom_range(MAX_ROW_WIDTH_DEF + 1, 8191);
            9:       width_word = $urandom_range(25, 700);
            default: width_word = $urandom_range(1, 24);
         endcase
         if (phase == 0) begin
            depth_word  = 0;
            width_word  = 1;
            bypass_word = 1;
         end else if (phase == 1) begin
            depth_word  = 3;
            width_word  = MAX_ROW_WIDTH_DEF;
            bypass_word = 0;
         end
         if ($urandom_range(0, 3) == 0)
            depth_word |= $urandom << DEPTH_W;
         if ($urandom_range(0, 3) == 0)
            width_word |= $urandom << ROW_WIDTH_W;
         if ($urandom_range(0, 3) == 0)
            bypass_word |= $urandom << 1;
         configure(depth_word, width_word, bypass_word);

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 3) == 0) begin
               send_request(OP_PAL_WRITE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
            end else if (sb.cfg.palette_bypass) begin
               // The palette result is not used in bypass mode, so any byte will do.
               send_request(OP_PIXEL, IDX_W'($urandom), IDX_W'($urandom), $urandom);
            end else begin
               // Build the byte from palette entries that are already loaded. Entry 0
               // is always loaded, so it serves when no other candidate turns up.
               bits       = 1 << sb.cfg.pixel_depth;
               pixel_byte = '0;
               for (int slot = 0; slot < 8 / bits; slot++) begin
                  cand  = $urandom_range(0, (1 << bits) - 1);
                  tries = 0;
                  while (!palette_loaded[cand] && tries < 16) begin
                     cand = $urandom_range(0, (1 << bits) - 1);
                     tries++;
                  end
                  if (!palette_loaded[cand])
                     cand = 0;
                  pixel_byte |= IDX_W'(cand << (8 - bits * (slot + 1)));
               end
               send_request(OP_PIXEL, pixel_byte, IDX_W'($urandom), $urandom);
            end
         end
      end

      // All stimulus is in; wait for the remaining pixels and then a little longer, so
      // that any surplus result is caught as unexpected.
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.errors == 0) begin
         $display("packed_index_palette_unpacker: match");
      end else begin
         $display("packed_index_palette_unpacker: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
